/* src/pvml_pkg.sv */
// ----------------------------------------------------------------------------
// pvml_pkg
// Shared types, register indexes, mode codes and helpers of the planar
// video memory latch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pvml_pkg;

    // geometry
    localparam int PLANE_ADDR_BITS_DEF = 16;
    localparam int PLANE_COUNT         = 4;
    localparam int LANE_W              = 8;
    localparam int WORD_W              = PLANE_COUNT * LANE_W;
    localparam int ADDR_W              = 16;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_FUNC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_SELECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MASK   = 3'd6;

    // write modes
    localparam logic [1:0] WM_FILL   = 2'd0;
    localparam logic [1:0] WM_LATCH  = 2'd1;
    localparam logic [1:0] WM_EXPAND = 2'd2;
    localparam logic [1:0] WM_ROTATE = 2'd3;

    // logic functions
    localparam logic [1:0] OP_REPLACE = 2'd0;
    localparam logic [1:0] OP_AND     = 2'd1;
    localparam logic [1:0] OP_OR      = 2'd2;
    localparam logic [1:0] OP_XOR     = 2'd3;

    // mode_bits fields
    localparam int MODE_COMPARE_BIT = 3;

    typedef struct packed {
        logic [3:0] plane_enable_mask;
        logic [3:0] fill_color;
        logic [3:0] fill_enable;
        logic [4:0] rotate_and_function;
        logic [1:0] plane_select;
        logic [7:0] mode_bits;
        logic [7:0] pixel_mask;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic rd;
        logic wr;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } sts_t;

    function automatic logic [LANE_W-1:0] rot_right8(input logic [LANE_W-1:0] d,
                                                     input logic [2:0] n);
        logic [2*LANE_W-1:0] dd;
        dd = {d, d} >> n;
        return dd[LANE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/pvml_regs.sv */
// ----------------------------------------------------------------------------
// pvml_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pvml_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pvml_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pvml_pkg::CFG_DATA_W-1:0] cfg_data,
    output pvml_pkg::cfg_t                       cfg
);
    import pvml_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLANE_ENABLE: cfg_next.plane_enable_mask   = cfg_data[3:0];
                REG_FILL_COLOR:   cfg_next.fill_color          = cfg_data[3:0];
                REG_FILL_ENABLE:  cfg_next.fill_enable         = cfg_data[3:0];
                REG_ROT_FUNC:     cfg_next.rotate_and_function = cfg_data[4:0];
                REG_PLANE_SELECT: cfg_next.plane_select        = cfg_data[1:0];
                REG_MODE:         cfg_next.mode_bits           = cfg_data;
                REG_PIXEL_MASK:   cfg_next.pixel_mask          = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane_enable_mask   <= 4'hF;
            cfg_reg.fill_color          <= 4'h0;
            cfg_reg.fill_enable         <= 4'h0;
            cfg_reg.rotate_and_function <= 5'h00;
            cfg_reg.plane_select        <= 2'd0;
            cfg_reg.mode_bits           <= 8'h00;
            cfg_reg.pixel_mask          <= 8'hFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* src/pvml_ctrl.sv */
// ----------------------------------------------------------------------------
// pvml_ctrl
// Sequencer: clearing pass, access issue, read completion and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module pvml_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           action,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  pvml_pkg::sts_t      sts,
    output pvml_pkg::cmd_t      cmd
);
    import pvml_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.rd       = accept && !action;
        cmd.wr       = accept && action;
        cmd.load     = (state_reg == ST_DONE) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && !action)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/pvml_dp.sv */
// ----------------------------------------------------------------------------
// pvml_dp
// Datapath: plane memory, latches, write data path and read result.
// ----------------------------------------------------------------------------
`default_nettype none

module pvml_dp #(
    parameter int PLANE_ADDR_BITS = pvml_pkg::PLANE_ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  pvml_pkg::cmd_t                    cmd,
    output pvml_pkg::sts_t                    sts,
    input  pvml_pkg::cfg_t                    cfg,
    input  wire logic [pvml_pkg::ADDR_W-1:0]  address,
    input  wire logic [pvml_pkg::LANE_W-1:0]  write_data,
    output logic [pvml_pkg::LANE_W-1:0]       read_data
);
    import pvml_pkg::*;

    localparam int DEPTH = 1 << PLANE_ADDR_BITS;

    logic [WORD_W-1:0]          mem [DEPTH];
    logic [WORD_W-1:0]          rdata_reg;
    logic [WORD_W-1:0]          latch_reg;
    logic [LANE_W-1:0]          read_data_reg;
    logic [PLANE_ADDR_BITS-1:0] clr_cnt_reg;
    logic [PLANE_ADDR_BITS-1:0] acc_addr;
    logic [PLANE_ADDR_BITS-1:0] mem_addr;
    logic [WORD_W-1:0]          wr_word;
    logic [PLANE_COUNT-1:0]     wr_en;
    logic [WORD_W-1:0]          mem_wdata;
    logic [LANE_W-1:0]          rd_result;
    logic [1:0]                 wmode;
    logic [1:0]                 op;
    logic [LANE_W-1:0]          rot_data;

    // address wraps to the store depth, or is zero-extended when the store is wider
    generate
        if (PLANE_ADDR_BITS <= ADDR_W)
        begin : g_addr_cut
            assign acc_addr = address[PLANE_ADDR_BITS-1:0];
        end
        else
        begin : g_addr_ext
            assign acc_addr = {{(PLANE_ADDR_BITS-ADDR_W){1'b0}}, address};
        end
    endgenerate

    assign wmode    = cfg.mode_bits[1:0];
    assign op       = cfg.rotate_and_function[4:3];
    assign rot_data = rot_right8(write_data, cfg.rotate_and_function[2:0]);

    assign sts.clear_last = &clr_cnt_reg;
    assign read_data      = read_data_reg;

    // per-plane write data
    always_comb
    begin
        logic [LANE_W-1:0] l;
        logic [LANE_W-1:0] d;
        logic [LANE_W-1:0] f;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            l = latch_reg[p*LANE_W +: LANE_W];
            case (wmode)
                WM_EXPAND: d = {LANE_W{write_data[p]}};
                WM_FILL:   d = cfg.fill_enable[p] ? {LANE_W{cfg.fill_color[p]}} : rot_data;
                default:   d = rot_data;
            endcase
            case (op)
                OP_AND:  f = d & l;
                OP_OR:   f = d | l;
                OP_XOR:  f = d ^ l;
                default: f = d;
            endcase
            if (wmode == WM_LATCH)
                wr_word[p*LANE_W +: LANE_W] = l;
            else
                wr_word[p*LANE_W +: LANE_W] = (f & cfg.pixel_mask) | (l & ~cfg.pixel_mask);
        end
    end

    // read result from the freshly read word
    always_comb
    begin
        logic [PLANE_COUNT-1:0] col;
        for (int b = 0; b < LANE_W; b++)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
                col[p] = rdata_reg[p*LANE_W + b];
            rd_result[b] = (col == cfg.fill_color);
        end
        if (!cfg.mode_bits[MODE_COMPARE_BIT])
            rd_result = rdata_reg[cfg.plane_select*LANE_W +: LANE_W];
    end

    assign mem_addr  = cmd.clear_wr ? clr_cnt_reg : acc_addr;
    assign mem_wdata = cmd.clear_wr ? '0 : wr_word;
    assign wr_en     = cmd.clear_wr ? {PLANE_COUNT{1'b1}}
                     : (cmd.wr ? cfg.plane_enable_mask : '0);

    // plane memory with lane write enables
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            if (wr_en[p])
                mem[mem_addr][p*LANE_W +: LANE_W] <= mem_wdata[p*LANE_W +: LANE_W];
        end
        if (cmd.rd)
            rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            read_data_reg <= rd_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                latch_reg <= rdata_reg;
            if (cmd.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* src/planar_video_memory_latch_unit.sv */
// ----------------------------------------------------------------------------
// planar_video_memory_latch_unit
// Four-plane video memory with processor latches, read/write modes and ALU.
// ----------------------------------------------------------------------------
// access: a write is stored as it is accepted; a read registers the memory
//   word, then moves it into the latches and result register once the output
//   slot is free; the single memory port keeps in_ready low until then
// throughput: one write per cycle while no read is pending
// reset: a clearing pass zeroes 2**PLANE_ADDR_BITS words (65536 by default)
//   of the plane memory, with in_ready low; configuration writes still taken
`default_nettype none

module planar_video_memory_latch_unit #(
    parameter int PLANE_ADDR_BITS = pvml_pkg::PLANE_ADDR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // access channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            action,
    input  wire logic [pvml_pkg::ADDR_W-1:0]     address,
    input  wire logic [pvml_pkg::LANE_W-1:0]     write_data,
    // read result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pvml_pkg::LANE_W-1:0]          read_data,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pvml_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pvml_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pvml_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // register file, always ready
    pvml_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: clear sweep, then idle / read completion
    // a read transaction loads the memory word, which then moves into
    // the latches and the result register once the output slot is free
    pvml_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // memory, latches, write modes, logic function, pixel mask, compare
    pvml_dp #(
        .PLANE_ADDR_BITS (PLANE_ADDR_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg        (cfg),
        .address    (address),
        .write_data (write_data),
        .read_data  (read_data)
    );

endmodule

`default_nettype wire

/* src/pvml_checker.sv */
// ----------------------------------------------------------------------------
// pvml_checker
// Port-level checks of the planar video memory latch unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pvml_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        action,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [pvml_pkg::LANE_W-1:0] read_data
);
    import pvml_pkg::*;

    // a read transaction blocks the next cycle
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !action) |=> !in_ready)
        else $error("input taken right after a read");

    // a write transaction leaves the input ready in the next cycle
    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action) |=> in_ready)
        else $error("write stalled the input");

    // a new result only follows a read in progress
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared with no read in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
        else $error("stalled result dropped or changed");

endmodule

bind planar_video_memory_latch_unit pvml_checker u_checker (.*);

`default_nettype wire
